// ===== design/sfl_pkg.sv =====
// sfl_pkg: shared types and constants for the sorted address floor lookup block
// no dependencies

package sfl_pkg;

    localparam int TABLE_ENTRIES_DEF = 8192;
    localparam int ADDRESS_BITS_DEF  = 32;
    localparam int TAG_BITS_DEF      = 16;
    localparam int ENTRY_COUNT_BITS  = 14;
    localparam int OP_BITS           = 2;
    localparam int STATUS_BITS       = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_NONE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_LOOKUP,
        S_SHIFT,
        S_INSERT,
        S_RESP
    } t_state;

endpackage

// ===== design/sfl_req_if.sv =====
// sfl_req_if: request channel (operation, address, tag) with valid/ready
// depends on sfl_pkg

interface sfl_req_if #(
    parameter int ADDR_W = sfl_pkg::ADDRESS_BITS_DEF,
    parameter int TAG_W  = sfl_pkg::TAG_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [sfl_pkg::OP_BITS-1:0]  operation;
    logic [ADDR_W-1:0]            address;
    logic [TAG_W-1:0]             tag;

    modport source (output valid, operation, address, tag, input ready);
    modport sink   (input valid, operation, address, tag, output ready);
endinterface

// ===== design/sfl_rsp_if.sv =====
// sfl_rsp_if: response channel (status, found tag, offset, entry count) with valid/ready
// depends on sfl_pkg

interface sfl_rsp_if #(
    parameter int ADDR_W = sfl_pkg::ADDRESS_BITS_DEF,
    parameter int TAG_W  = sfl_pkg::TAG_BITS_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic [sfl_pkg::STATUS_BITS-1:0]       status;
    logic [TAG_W-1:0]                      found_tag;
    logic [ADDR_W-1:0]                     offset;
    logic [sfl_pkg::ENTRY_COUNT_BITS-1:0]  entry_count;

    modport source (output valid, status, found_tag, offset, entry_count, input ready);
    modport sink   (input valid, status, found_tag, offset, entry_count, output ready);
endinterface

// ===== design/sfl_ram.sv =====
// sfl_ram: generic single-write, single-read memory with registered read data
// depends on sfl_pkg for default sizes

module sfl_ram #(
    parameter int WIDTH = sfl_pkg::ADDRESS_BITS_DEF + sfl_pkg::TAG_BITS_DEF,
    parameter int DEPTH = sfl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== design/sorted_address_floor_lookup_top.sv =====
// sorted_address_floor_lookup_top: sorted (start, tag) table with floor lookup
// depends on sfl_pkg, sfl_req_if, sfl_rsp_if and sfl_ram

// The table lives in one memory kept sorted by start address; entries with equal
// starts keep insertion order, so a lookup returns the one inserted last. Each
// request gives exactly one response. A clear goes from acceptance straight to the
// response state, and so does an insert into a full table. A lookup binary-searches
// the held entries with one memory read per cycle. An insert runs the same search,
// then moves every entry above the insert point up by one place, one entry per
// cycle through the memory's read and write ports, then writes the new entry. A new
// request is taken while the previous response still waits on the output register.

module sorted_address_floor_lookup_top #(
    parameter int TABLE_ENTRIES = sfl_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = sfl_pkg::ADDRESS_BITS_DEF,
    parameter int TAG_BITS      = sfl_pkg::TAG_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfl_req_if.sink   i_req,
    sfl_rsp_if.source o_rsp
);
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int MW  = ADDRESS_BITS + TAG_BITS;
    localparam int ECW = sfl_pkg::ENTRY_COUNT_BITS;

    sfl_pkg::t_state  r_state, n_state;
    logic             r_is_insert, n_is_insert;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [TAG_BITS-1:0]     r_tag, n_tag;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic             r_pend, n_pend;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_src, n_src;
    logic [IW-1:0]    r_widx, n_widx;
    logic             r_wpend, n_wpend;
    logic [CW-1:0]    r_count, n_count;

    sfl_pkg::t_status        r_res_status, n_res_status;
    logic [TAG_BITS-1:0]     r_res_tag, n_res_tag;
    logic [ADDRESS_BITS-1:0] r_res_offset, n_res_offset;

    logic                             r_out_valid, n_out_valid;
    logic [sfl_pkg::STATUS_BITS-1:0]  r_out_status, n_out_status;
    logic [TAG_BITS-1:0]              r_out_tag, n_out_tag;
    logic [ADDRESS_BITS-1:0]          r_out_offset, n_out_offset;
    logic [ECW-1:0]                   r_out_count, n_out_count;

    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [MW-1:0] wr_data, rd_data;
    logic [ADDRESS_BITS-1:0] rd_start;
    logic [TAG_BITS-1:0]     rd_tag;
    logic [CW-1:0] lo_v, hi_v, mid_v, idx_v;

    assign rd_start = rd_data[MW-1:TAG_BITS];
    assign rd_tag   = rd_data[TAG_BITS-1:0];

    sfl_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfl_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_insert  <= n_is_insert;
        r_addr       <= n_addr;
        r_tag        <= n_tag;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_pos        <= n_pos;
        r_src        <= n_src;
        r_widx       <= n_widx;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_res_offset <= n_res_offset;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
        r_out_offset <= n_out_offset;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_is_insert  = r_is_insert;
        n_addr       = r_addr;
        n_tag        = r_tag;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_pend       = r_pend;
        n_pos        = r_pos;
        n_src        = r_src;
        n_widx       = r_widx;
        n_wpend      = r_wpend;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_res_offset = r_res_offset;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_offset = r_out_offset;
        n_out_count  = r_out_count;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        lo_v         = r_lo;
        hi_v         = r_hi;
        mid_v        = '0;
        idx_v        = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            sfl_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_addr       = i_req.address;
                    n_tag        = i_req.tag;
                    n_lo         = '0;
                    n_hi         = r_count;
                    n_pend       = 1'b0;
                    n_res_status = sfl_pkg::STAT_OK;
                    n_res_tag    = '0;
                    n_res_offset = '0;
                    case (i_req.operation)
                        sfl_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = sfl_pkg::S_RESP;
                        end
                        sfl_pkg::OP_INSERT: begin
                            if (r_count >= CW'(TABLE_ENTRIES)) begin
                                n_res_status = sfl_pkg::STAT_FULL;
                                n_state      = sfl_pkg::S_RESP;
                            end else begin
                                n_is_insert = 1'b1;
                                n_state     = sfl_pkg::S_SEARCH;
                            end
                        end
                        sfl_pkg::OP_LOOKUP: begin
                            n_is_insert = 1'b0;
                            n_state     = sfl_pkg::S_SEARCH;
                        end
                        default: begin
                            n_state = sfl_pkg::S_RESP;
                        end
                    endcase
                end
            end

            sfl_pkg::S_SEARCH: begin
                // first index whose start is above the address
                if (r_pend) begin
                    if (rd_start > r_addr) begin
                        hi_v = r_mid;
                    end else begin
                        lo_v = r_mid + CW'(1);
                    end
                end
                n_lo = lo_v;
                n_hi = hi_v;
                if (lo_v < hi_v) begin
                    mid_v   = lo_v + ((hi_v - lo_v) >> 1);
                    rd_en   = 1'b1;
                    rd_addr = mid_v[IW-1:0];
                    n_mid   = mid_v;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    n_pos  = lo_v;
                    if (r_is_insert) begin
                        n_src   = r_count;
                        n_wpend = 1'b0;
                        n_state = sfl_pkg::S_SHIFT;
                    end else if (lo_v == '0) begin
                        n_res_status = sfl_pkg::STAT_NONE;
                        n_res_offset = r_addr;
                        n_state      = sfl_pkg::S_RESP;
                    end else begin
                        idx_v   = lo_v - CW'(1);
                        rd_en   = 1'b1;
                        rd_addr = idx_v[IW-1:0];
                        n_state = sfl_pkg::S_LOOKUP;
                    end
                end
            end

            sfl_pkg::S_LOOKUP: begin
                n_res_tag    = rd_tag;
                n_res_offset = r_addr - rd_start;
                n_state      = sfl_pkg::S_RESP;
            end

            sfl_pkg::S_SHIFT: begin
                // read entry i, write it to i + 1 in the next cycle
                if (r_wpend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_widx;
                    wr_data = rd_data;
                end
                if (r_src > r_pos) begin
                    idx_v   = r_src - CW'(1);
                    rd_en   = 1'b1;
                    rd_addr = idx_v[IW-1:0];
                    n_widx  = r_src[IW-1:0];
                    n_wpend = 1'b1;
                    n_src   = idx_v;
                end else begin
                    n_wpend = 1'b0;
                    n_state = sfl_pkg::S_INSERT;
                end
            end

            sfl_pkg::S_INSERT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IW-1:0];
                wr_data = {r_addr, r_tag};
                n_count = r_count + CW'(1);
                n_state = sfl_pkg::S_RESP;
            end

            sfl_pkg::S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_tag    = r_res_tag;
                    n_out_offset = r_res_offset;
                    n_out_count  = ECW'(r_count);
                    n_state      = sfl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sfl_pkg::S_IDLE;
            end
        endcase
    end

    assign i_req.ready       = (r_state == sfl_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_tag   = r_out_tag;
    assign o_rsp.offset      = r_out_offset;
    assign o_rsp.entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfl_pkg::S_INSERT) |-> (r_count < CW'(TABLE_ENTRIES)))
        else $error("insert write into full table");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("memory read and write hit the same entry");

    a_resp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfl_pkg::S_RESP && (!r_out_valid || o_rsp.ready))
            |=> (r_out_valid && r_state == sfl_pkg::S_IDLE))
        else $error("response not loaded into output register");

endmodule
